// ----- hdl/ssld_pkg.sv -----
// Package for the seven-segment serial link driver.
// Holds slot kind codes, request codes, the slot decoder and the digit table.
// No dependencies.
package ssld_pkg;

  localparam int POSITIONS_DEFAULT = 4;

  // Request codes carried in the input tuser
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_COMMAND = 2'd1;
  localparam logic [1:0] OP_SEGMENT = 2'd2;
  localparam logic [1:0] OP_DIGIT   = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] REG_DATA_COMMAND    = 8'd0;
  localparam logic [7:0] REG_ADDRESS_COMMAND = 8'd1;

  localparam logic [7:0] DATA_COMMAND_RESET    = 8'h44;
  localparam logic [7:0] ADDRESS_COMMAND_RESET = 8'hC0;

  // Slot kinds
  localparam logic [3:0] K_IDLE     = 4'd0;
  localparam logic [3:0] K_START    = 4'd1;
  localparam logic [3:0] K_HOLD     = 4'd2;
  localparam logic [3:0] K_LOW      = 4'd3;
  localparam logic [3:0] K_HIGH     = 4'd4;
  localparam logic [3:0] K_REL_LOW  = 4'd5;
  localparam logic [3:0] K_REL_HIGH = 4'd6;
  localparam logic [3:0] K_ACK_END  = 4'd7;
  localparam logic [3:0] K_STOP     = 4'd8;

  // Phase layout: bit 6 marks a single-frame command, low six bits count slots
  localparam logic [5:0] FRAME0_LAST  = 6'd22;
  localparam logic [6:0] FRAME1_LAST  = 7'd63;
  localparam logic [6:0] PHASE_FIRST  = 7'd1;
  localparam logic [6:0] PHASE_SINGLE = 7'd65;
  localparam logic [5:0] BYTE_SLOTS   = 6'd19;

  typedef struct packed {
    logic [3:0] kind;
    logic       frame;
    logic       bidx;
    logic [4:0] sub;
  } slot_t;

  function automatic slot_t slot_decode(input logic [6:0] p);
    slot_t      s;
    logic [5:0] q;
    logic [5:0] o;
    logic [5:0] r;
    logic [5:0] stop_o;
    logic [5:0] sub_w;
    s = '0;
    q = p[5:0];
    s.frame = (q > FRAME0_LAST);
    o = s.frame ? (q - (FRAME0_LAST + 6'd1)) : (q - 6'd1);
    stop_o = s.frame ? (6'd2 + 6'd2 * BYTE_SLOTS) : (6'd2 + BYTE_SLOTS);
    r = o - 6'd2;
    s.bidx = (r >= BYTE_SLOTS);
    sub_w = s.bidx ? (r - BYTE_SLOTS) : r;
    s.sub = sub_w[4:0];
    if (q == 6'd0 || (p[6] && s.frame)) begin
      s = '0;
    end else if (o == 6'd0) begin
      s.kind = K_START;
    end else if (o == 6'd1) begin
      s.kind = K_HOLD;
    end else if (o == stop_o) begin
      s.kind = K_STOP;
    end else if (o > stop_o) begin
      s = '0;
    end else if (sub_w < 6'd16) begin
      s.kind = sub_w[0] ? K_HIGH : K_LOW;
    end else if (sub_w == 6'd16) begin
      s.kind = K_REL_LOW;
    end else if (sub_w == 6'd17) begin
      s.kind = K_REL_HIGH;
    end else begin
      s.kind = K_ACK_END;
    end
    return s;
  endfunction

  function automatic logic [7:0] digit_segments(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- hdl/seven_segment_serial_link_driver.sv -----
// Two-wire seven-segment display link driver, top level.
// Each result is registered; it appears in the cycle after its input is accepted.
// Throughput: one transaction per cycle while the result is not stalled; the slot
// step is one pass through the phase decoder between the state and result registers.
// Reset (rst, synchronous): idle phase, lines at clock 1 / data 1, ack 0,
// command registers at 0x44 and 0xC0, no result pending.
// Depends on ssld_pkg.
module seven_segment_serial_link_driver
  import ssld_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // request / tick stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [15:0] s_tdata,  // position[1:0], payload[9:2], colon[10], dio_in[11], zeros
  input  logic [1:0] s_tuser,   // op[1:0]
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // clk_out[0], dio_out[1], dio_drive[2], busy_res[3],
                                // ack_bit[4], rejected[5], zeros
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [7:0] POS_MASK = 8'(POSITIONS - 1);

  // Sequencer state
  logic [6:0] phase, phase_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] address_byte, address_byte_next;
  logic [7:0] segment_byte, segment_byte_next;
  logic       ack_register, ack_register_next;
  logic [7:0] data_command, address_command;

  logic       s_fire;
  logic [1:0] op;
  logic [1:0] position;
  logic [7:0] payload;
  logic       colon;
  logic       dio_in;

  logic [7:0] seg;
  slot_t      cur_slot, step_slot, fin_slot;
  logic       clk_level, data_level, drive, rejected;

  // Take a new transaction whenever the result register is empty or draining
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign op       = s_tuser;
  assign position = s_tdata[1:0];
  assign payload  = s_tdata[9:2];
  assign colon    = s_tdata[10];
  assign dio_in   = s_tdata[11];

  always_comb begin
    phase_next        = phase;
    shift_byte_next   = shift_byte;
    address_byte_next = address_byte;
    segment_byte_next = segment_byte;
    ack_register_next = ack_register;
    rejected          = 1'b0;
    seg               = payload;
    cur_slot          = slot_decode(phase);
    step_slot         = '0;

    if (op != OP_TICK) begin
      // Requests start only from idle; digits above nine are refused outright
      if (phase != 7'd0 || (op == OP_DIGIT && payload > 8'd9)) begin
        rejected = 1'b1;
      end else if (op == OP_COMMAND) begin
        shift_byte_next = payload;
        phase_next      = PHASE_SINGLE;
      end else begin
        if (op == OP_DIGIT) begin
          seg = digit_segments(payload[3:0]);
        end
        // Colon lives in bit 7 of the second position
        if (position == 2'd1) begin
          seg[7] = colon;
        end
        segment_byte_next = seg;
        address_byte_next = address_command | ({6'd0, position} & POS_MASK);
        shift_byte_next   = data_command;
        phase_next        = PHASE_FIRST;
      end
    end else if (phase != 7'd0) begin
      if (cur_slot.kind == K_HIGH) begin
        shift_byte_next = {1'b0, shift_byte[7:1]};
      end
      if (cur_slot.kind == K_REL_HIGH) begin
        ack_register_next = dio_in;
      end
      // Drop to idle after the stop slot of the last frame
      if (cur_slot.kind == K_IDLE || (phase[6] && phase[5:0] == FRAME0_LAST) ||
          phase == FRAME1_LAST) begin
        phase_next = 7'd0;
      end else begin
        phase_next = phase + 7'd1;
      end
      // Load address or segment byte at the first bit slot of each byte in frame 1
      step_slot = slot_decode(phase_next);
      if (step_slot.kind == K_LOW && step_slot.sub == 5'd0 && step_slot.frame) begin
        shift_byte_next = step_slot.bidx ? segment_byte : address_byte;
      end
    end

    fin_slot = slot_decode(phase_next);
    if (fin_slot.kind == K_IDLE) begin
      phase_next = 7'd0;
    end

    drive = 1'b1;
    case (fin_slot.kind)
      K_START:    begin clk_level = 1'b1; data_level = 1'b1; end
      K_HOLD:     begin clk_level = 1'b1; data_level = 1'b0; end
      K_LOW:      begin clk_level = 1'b0; data_level = shift_byte_next[0]; end
      K_HIGH:     begin clk_level = 1'b1; data_level = shift_byte_next[0]; end
      K_REL_LOW:  begin clk_level = 1'b0; data_level = 1'b0; drive = 1'b0; end
      K_REL_HIGH: begin clk_level = 1'b1; data_level = 1'b0; drive = 1'b0; end
      K_ACK_END:  begin clk_level = 1'b0; data_level = 1'b0; end
      K_STOP:     begin clk_level = 1'b1; data_level = 1'b0; end
      default:    begin clk_level = 1'b1; data_level = 1'b1; end
    endcase
  end

  // Advance state and load the result register on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 7'd0;
      shift_byte   <= 8'd0;
      address_byte <= 8'd0;
      segment_byte <= 8'd0;
      ack_register <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s_fire) begin
        phase        <= phase_next;
        shift_byte   <= shift_byte_next;
        address_byte <= address_byte_next;
        segment_byte <= segment_byte_next;
        ack_register <= ack_register_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {2'b00, rejected, ack_register_next, (phase_next != 7'd0),
                  drive, data_level, clk_level};
    end
  end

  // Configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      data_command    <= DATA_COMMAND_RESET;
      address_command <= ADDRESS_COMMAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DATA_COMMAND:    data_command    <= cfg_data;
        REG_ADDRESS_COMMAND: address_command <= cfg_data;
        default: ;
      endcase
    end
  end

  // A request refused while busy must not move the sequencer
  assert property (@(posedge clk) disable iff (rst)
    s_fire && phase != 7'd0 && op != OP_TICK |=> $stable(phase))
    else $error("busy request advanced the phase");

  // A stalled result blocks new input
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted over a stalled result");

  // A released data wire only occurs inside a transfer
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[3])
    else $error("data wire released while idle");

  // Phase stays within the two frame layouts
  assert property (@(posedge clk) disable iff (rst)
    phase <= FRAME1_LAST || (phase >= PHASE_SINGLE && phase <= 7'd86))
    else $error("phase outside frame layout");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-wire seven-segment link driver.
// A scoreboard class predicts every result transaction from the accepted
// request/tick transactions; plain tasks drive the streams. Depends on ssld_pkg.
module tb_top
  import ssld_pkg::*;
();

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_IDLE      = 11;    // longest gap either side draws
  localparam int LONG_HOLD     = 300;   // long receiver hold-off, in cycles
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int PHASE_ITEMS   = 20;    // random items per configuration phase
  localparam int RANDOM_PHASES = 6;

  // One predicted result, same field order as m_tdata from the top bit down
  typedef struct packed {
    bit rejected;
    bit ack_bit;
    bit busy_res;
    bit dio_drive;
    bit dio_out;
    bit clk_out;
  } wire_levels_t;

  // Predicts the wire levels produced by each accepted transaction and
  // checks the result stream against them in order.
  class link_level_model;
    localparam int LAST_SINGLE_SLOT = 22;  // stop slot of a lone command frame
    localparam int LAST_SLOT        = 63;  // stop slot of the second frame
    localparam int SLOTS_PER_BYTE   = 19;

    bit [7:0]     data_cmd;
    bit [7:0]     addr_cmd;
    bit [6:0]     phase;
    bit [7:0]     shift_r;
    bit [7:0]     addr_r;
    bit [7:0]     seg_r;
    bit           clk_l;
    bit           dio_l;
    bit           ack_r;
    bit [7:0]     digit_segs[10];
    wire_levels_t levels_due[$];
    int           errors;
    int           checked;
    int           rejects;

    function new();
      digit_segs = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
      data_cmd = DATA_COMMAND_RESET;
      addr_cmd = ADDRESS_COMMAND_RESET;
      phase    = '0;
      shift_r  = '0;
      addr_r   = '0;
      seg_r    = '0;
      clk_l    = 1'b1;
      dio_l    = 1'b1;
      ack_r    = 1'b0;
      errors   = 0;
      checked  = 0;
      rejects  = 0;
    endfunction

    function void write_reg(bit [7:0] idx, bit [7:0] val);
      if (idx == REG_DATA_COMMAND) data_cmd = val;
      else if (idx == REG_ADDRESS_COMMAND) addr_cmd = val;
    endfunction

    function bit busy();
      return phase != 0;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    // Decode a phase count into the slot it stands for
    function void slot_of(input bit [6:0] p, output bit [3:0] kind, output bit frame,
                          output bit bidx, output int sub);
      int q;
      int o;
      int stop_at;
      kind  = K_IDLE;
      frame = 1'b0;
      bidx  = 1'b0;
      sub   = 0;
      q = int'(p[5:0]);
      if (q == 0) return;
      if (p[6] && q > LAST_SINGLE_SLOT) return;
      frame   = (q > LAST_SINGLE_SLOT);
      o       = frame ? q - (LAST_SINGLE_SLOT + 1) : q - 1;
      stop_at = frame ? 2 + 2 * SLOTS_PER_BYTE : 2 + SLOTS_PER_BYTE;
      if (o == 0) kind = K_START;
      else if (o == 1) kind = K_HOLD;
      else if (o == stop_at) kind = K_STOP;
      else if (o < stop_at) begin
        bidx = ((o - 2) >= SLOTS_PER_BYTE);
        sub  = (o - 2) % SLOTS_PER_BYTE;
        if (sub < 16) kind = (sub % 2 == 1) ? K_HIGH : K_LOW;
        else if (sub == 16) kind = K_REL_LOW;
        else if (sub == 17) kind = K_REL_HIGH;
        else kind = K_ACK_END;
      end
    endfunction

    // Advance the link by one accepted transaction and queue its result
    function void take_request(bit [1:0] op, bit [1:0] pos, bit [7:0] payload,
                               bit colon, bit dio);
      wire_levels_t lv;
      bit [3:0]     kind;
      bit           frame;
      bit           bidx;
      int           sub;
      bit [7:0]     seg;
      bit [1:0]     pos_mask;
      lv = '0;
      lv.dio_drive = 1'b1;
      pos_mask = 2'(POSITIONS_DEFAULT - 1);
      if (op != OP_TICK) begin
        if (phase != 0 || (op == OP_DIGIT && payload > 8'd9)) begin
          lv.rejected = 1'b1;
          rejects++;
        end else if (op == OP_COMMAND) begin
          shift_r = payload;
          phase   = PHASE_SINGLE;
        end else begin
          seg = (op == OP_DIGIT) ? digit_segs[payload[3:0]] : payload;
          // the colon lives in bit 7 of the second digit only
          if (pos == 2'd1) seg[7] = colon;
          seg_r   = seg;
          addr_r  = addr_cmd | {6'b0, pos & pos_mask};
          shift_r = data_cmd;
          phase   = PHASE_FIRST;
        end
      end else if (phase != 0) begin
        slot_of(phase, kind, frame, bidx, sub);
        if (kind == K_HIGH) shift_r = shift_r >> 1;
        if (kind == K_REL_HIGH) ack_r = dio;
        if (kind == K_IDLE || (phase[6] && phase[5:0] == LAST_SINGLE_SLOT) ||
            phase == LAST_SLOT)
          phase = '0;
        else
          phase = phase + 7'd1;
        // load the next byte of the second frame at its first bit slot
        slot_of(phase, kind, frame, bidx, sub);
        if (kind == K_LOW && sub == 0 && frame) shift_r = bidx ? seg_r : addr_r;
      end

      slot_of(phase, kind, frame, bidx, sub);
      if (kind == K_IDLE) phase = '0;
      case (kind)
        K_START:    begin clk_l = 1'b1; dio_l = 1'b1; end
        K_HOLD:     begin clk_l = 1'b1; dio_l = 1'b0; end
        K_LOW:      begin clk_l = 1'b0; dio_l = shift_r[0]; end
        K_HIGH:     begin clk_l = 1'b1; dio_l = shift_r[0]; end
        K_REL_LOW:  begin clk_l = 1'b0; dio_l = 1'b0; lv.dio_drive = 1'b0; end
        K_REL_HIGH: begin clk_l = 1'b1; dio_l = 1'b0; lv.dio_drive = 1'b0; end
        K_ACK_END:  begin clk_l = 1'b0; dio_l = 1'b0; end
        K_STOP:     begin clk_l = 1'b1; dio_l = 1'b0; end
        default:    begin clk_l = 1'b1; dio_l = 1'b1; end
      endcase
      lv.clk_out  = clk_l;
      lv.dio_out  = dio_l;
      lv.busy_res = (phase != 0);
      lv.ack_bit  = ack_r;
      levels_due.push_back(lv);
    endfunction

    function void compare_field(string name, bit exp_v, bit act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_levels(logic [7:0] d);
      wire_levels_t e;
      if (levels_due.size() == 0) begin
        $error("result 0x%02h arrived with nothing expected", d);
        errors++;
        return;
      end
      e = levels_due.pop_front();
      checked++;
      compare_field("clk_out", e.clk_out, d[0]);
      compare_field("dio_out", e.dio_out, d[1]);
      compare_field("dio_drive", e.dio_drive, d[2]);
      compare_field("busy_res", e.busy_res, d[3]);
      compare_field("ack_bit", e.ack_bit, d[4]);
      compare_field("rejected", e.rejected, d[5]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  link_level_model model;
  int items_sent;
  int reg_writes;
  int long_holds;
  bit sender_steady;   // sender offers back to back while set
  bit rx_steady;       // receiver draws no random stall while set
  bit hold_off_req;    // ask the receiver for one long hold-off

  seven_segment_serial_link_driver uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Offer one transaction at a falling edge, hold it until accepted, then
  // draw the gap before the next one. Drop valid only when a gap follows.
  task automatic send_item(input bit [1:0] op, input bit [1:0] pos, input bit [7:0] payload,
                           input bit colon, input bit dio);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, dio, colon, payload, pos};
    do @(posedge clk); while (!s_tready);
    model.take_request(op, pos, payload, colon, dio);
    items_sent++;
    @(negedge clk);
    gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Tick with random position, payload, colon and dio fields so those input bits toggle
  task automatic send_tick();
    send_item(OP_TICK, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Tick the link until the current transfer has finished; now and then
  // slip in a request while busy, which must be turned away.
  task automatic drain_link();
    while (model.busy()) begin
      if ($urandom_range(0, 19) == 0)
        send_item(2'($urandom_range(1, 3)), 2'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom));
      else
        send_tick();
    end
  endtask

  task automatic run_request(input bit [1:0] op, input bit [1:0] pos, input bit [7:0] payload,
                             input bit colon);
    send_item(op, pos, payload, colon, 1'($urandom));
    drain_link();
  endtask

  // Pause the sender until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    // leave a little margin
    repeat (3) @(negedge clk);
  endtask

  // Write both registers, optionally followed by a write to an unused index
  task automatic program_regs(input bit [7:0] dcmd, input bit [7:0] acmd, input bit stray);
    bit [7:0] idx[3];
    bit [7:0] val[3];
    int       n;
    idx[0] = REG_DATA_COMMAND;
    val[0] = dcmd;
    idx[1] = REG_ADDRESS_COMMAND;
    val[1] = acmd;
    idx[2] = 8'($urandom_range(2, 255));
    val[2] = 8'($urandom);
    n = stray ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      model.write_reg(idx[i], val[i]);
      reg_writes++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: draw a stall per result, or honor a long hold-off request
  initial begin
    int stall;
    int results;
    bit hold_taken;
    results    = 0;
    hold_taken = 1'b0;
    m_tready   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req && !hold_taken) begin
        stall = LONG_HOLD;
        hold_taken = 1'b1;
        long_holds++;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      model.check_levels(m_tdata);
      results++;
      // switch between stalling and steady stretches now and then
      if (results % 97 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    bit [1:0] d_op[11];
    bit [1:0] d_pos[11];
    bit [7:0] d_pay[11];
    bit       d_col[11];
    bit [1:0] op;
    bit [7:0] payload;
    int       target;

    model         = new();
    items_sent    = 0;
    reg_writes    = 0;
    sender_steady = 1'b0;
    hold_off_req  = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_TICK;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed requests at reset register values: tick while idle, command
    // extremes, colon set and cleared at the second digit, colon ignored
    // elsewhere, digit table ends and out-of-range digits while idle.
    d_op  = '{OP_TICK, OP_COMMAND, OP_COMMAND, OP_SEGMENT, OP_SEGMENT, OP_SEGMENT,
              OP_DIGIT, OP_DIGIT, OP_DIGIT, OP_DIGIT, OP_DIGIT};
    d_pos = '{2'd0, 2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd1};
    d_pay = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd0, 8'd9, 8'd10, 8'hFF, 8'd8};
    d_col = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    for (int i = 0; i < 11; i++) begin
      send_item(d_op[i], d_pos[i], d_pay[i], d_col[i], 1'($urandom));
      // a request right on the heels of the one just started is refused
      if (i == 2) send_item(OP_SEGMENT, 2'd1, 8'hA5, 1'b1, 1'b0);
      drain_link();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: program_regs(8'h00, 8'h00, 1'b1);
        2: program_regs(8'hFF, 8'hFF, 1'b0);
        3: program_regs(8'($urandom), 8'($urandom), 1'b1);
        4: program_regs(DATA_COMMAND_RESET, ADDRESS_COMMAND_RESET, 1'b0);
        5: program_regs(8'($urandom), 8'($urandom), 1'b0);
        default: ;
      endcase
      // phase 2: starve the result side while the sender streams on
      sender_steady = (ph == 2) || (ph == 4);
      if (ph == 2) hold_off_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: any field combination
          send_item(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          op = 2'($urandom_range(1, 3));
          payload = 8'($urandom);
          if (op == OP_DIGIT && $urandom_range(0, 4) != 0) payload = 8'($urandom_range(0, 9));
          if ($urandom_range(0, 7) == 0) payload = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          run_request(op, 2'($urandom), payload, 1'($urandom));
        end
      end
      drain_link();
      sender_steady = 1'b0;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("summary: %0d transactions sent, %0d results checked, %0d refused requests",
             items_sent, model.checked, model.rejects);
    $display("summary: %0d register writes over %0d phases, %0d long result hold-offs",
             reg_writes, RANDOM_PHASES, long_holds);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
